// File: rtl/core/gkb_pkg.sv
// Shared types and constants of the gaussian kernel builder.
// No dependencies; gkb_div, gkb_datapath, gkb_ctrl and the top level take names from here by scope.
`timescale 1ns / 1ps

package gkb_pkg;

    // shared divider geometry
    localparam int DIV_NW = 45;   // dividend bits
    localparam int DIV_DW = 36;   // divisor bits
    localparam int DIV_QW = 24;   // kept quotient bits, overflow is sticky
    localparam int DIV_CW = 6;    // iteration counter

    localparam logic [23:0] T_LIMIT = 24'd2097152;   // 32.0 in Q16
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [6:0]  N_LIMIT = 7'd16;
    localparam logic [39:0] RECIP_ONE = 40'h80_0000_0000;  // 2^39
    localparam logic [40:0] OUT_ROUND = 41'h00_0040_0000;  // 2^22

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SETUP,
        OP_TAP,
        OP_EXPU,
        OP_HORNER,
        OP_RAW,
        OP_RECIP,
        OP_INV,
        OP_RDMEM,
        OP_OUT,
        OP_NEXT,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic bad;        // latched request is rejected
        logic div_done;   // divider quotient valid this cycle
        logic k_zero;     // last polynomial step
        logic last_tap;   // tap index at +r
        logic out_last;   // result register holds the final result
    } t_stat;

    // ln2^k / k! in Q30
    function automatic logic [30:0] exp2_coef(input logic [2:0] k);
        logic [30:0] c;
        case (k)
            3'd0:    c = 31'd1073741824;
            3'd1:    c = 31'd744261118;
            3'd2:    c = 31'd257941248;
            3'd3:    c = 31'd59597084;
            3'd4:    c = 31'd10327388;
            3'd5:    c = 31'd1431680;
            3'd6:    c = 31'd165394;
            default: c = 31'd0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/gkb_if.sv
// Request and result channel interfaces of the gaussian kernel builder.
// Plain valid/ready channels; no dependencies.
`timescale 1ns / 1ps

interface gkb_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] radius_q8;
    logic [15:0] sigma_q8;

    modport source (output valid, radius_q8, sigma_q8, input ready);
    modport sink   (input valid, radius_q8, sigma_q8, output ready);
endinterface

interface gkb_res_if;
    logic              valid;
    logic              ready;
    logic [15:0]       weight;
    logic signed [5:0] tap_offset;
    logic              last;
    logic              bad_request;

    modport source (output valid, weight, tap_offset, last, bad_request, input ready);
    modport sink   (input valid, weight, tap_offset, last, bad_request, output ready);
endinterface

// File: rtl/core/gkb_div.sv
// Restoring divider, one quotient bit per cycle, shared by taps and reciprocal.
// Uses gkb_pkg for its widths.
`timescale 1ns / 1ps

module gkb_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gkb_pkg::DIV_NW-1:0]    i_num,
    input  logic [gkb_pkg::DIV_DW-1:0]    i_den,
    output logic                          o_done,
    output logic [gkb_pkg::DIV_QW-1:0]    o_quot,
    output logic                          o_ovf
);

    localparam int NW = gkb_pkg::DIV_NW;
    localparam int DW = gkb_pkg::DIV_DW;
    localparam int QW = gkb_pkg::DIV_QW;
    localparam int CW = gkb_pkg::DIV_CW;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_quot;
    logic          r_ovf;

    logic [DW:0] rem_sh;
    logic [DW:0] diff;
    logic        ge;

    assign rem_sh = {r_rem, r_num[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath of the divider, no reset
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_num  <= {r_num[NW-2:0], 1'b0};
            r_rem  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            r_quot <= {r_quot[QW-2:0], ge};
            r_ovf  <= r_ovf | r_quot[QW-1];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

endmodule

// File: rtl/core/gkb_datapath.sv
// Datapath: operand registers, exp polynomial, tap store, sum and scaling.
// Uses gkb_pkg and instantiates gkb_div.
`timescale 1ns / 1ps

module gkb_datapath #(
    parameter int MAX_RADIUS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gkb_pkg::t_cmd      i_cmd,
    output gkb_pkg::t_stat     o_stat,
    input  logic [15:0]        i_radius_q8,
    input  logic [15:0]        i_sigma_q8,
    output logic [15:0]        o_weight,
    output logic signed [5:0]  o_tap_offset,
    output logic               o_last,
    output logic               o_bad_request
);

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam logic [16:0] BAD_LIM = 17'(MAX_RADIUS * 256);

    logic [15:0]   r_radius;
    logic [17:0]   r_q;
    logic [RW-1:0] r_r;
    logic [IW-1:0] r_idx;
    logic [35:0]   r_qsq;
    logic          r_zero;
    logic [6:0]    r_n;
    logic [15:0]   r_f;
    logic [30:0]   r_p;
    logic [2:0]    r_k;
    logic [22:0]   r_sum;
    logic [23:0]   r_inv;
    logic [16:0]   r_rd;
    logic [16:0]   r_mem [DEPTH];

    logic [15:0]       r_o_weight;
    logic signed [5:0] r_o_offset;
    logic              r_o_last;
    logic              r_o_bad;

    // tap geometry
    logic [6:0]  off7;
    logic [5:0]  abs6;
    logic [11:0] sq;
    logic [13:0] x9;
    logic        last_tap;

    assign off7     = 7'(r_idx) - 7'(r_r);
    assign abs6     = off7[6] ? 6'(-off7) : off7[5:0];
    assign sq       = abs6 * abs6;
    assign x9       = sq[9:0] * 14'd9;
    assign last_tap = r_idx == IW'({r_r, 1'b0});

    // divider
    logic                           div_start;
    logic [gkb_pkg::DIV_NW-1:0]     div_num;
    logic [gkb_pkg::DIV_DW-1:0]     div_den;
    logic                           div_done;
    logic [gkb_pkg::DIV_QW-1:0]     div_quot;
    logic                           div_ovf;

    assign div_start = (i_cmd.op == gkb_pkg::OP_TAP) || (i_cmd.op == gkb_pkg::OP_RECIP);
    assign div_num   = (i_cmd.op == gkb_pkg::OP_RECIP)
                     ? gkb_pkg::DIV_NW'(gkb_pkg::RECIP_ONE + 40'(r_sum >> 1))
                     : {x9, 31'd0};
    assign div_den   = (i_cmd.op == gkb_pkg::OP_RECIP) ? 36'(r_sum) : r_qsq;

    gkb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    // combinational arithmetic of each step
    logic [17:0] q_in;
    logic [35:0] qsq;
    logic        t_big;
    logic [38:0] uprod;
    logic [46:0] hprod;
    logic [30:0] hs;
    logic [30:0] coef;
    logic [30:0] p_next;
    logic        raw_zero;
    logic [4:0]  sh;
    logic [31:0] rnd;
    logic [31:0] s32;
    logic [16:0] raw;
    logic [40:0] oprod;
    logic [40:0] oadd;
    logic [17:0] w18;

    assign q_in   = (i_sigma_q8 != 16'd0) ? 18'(i_sigma_q8) * 18'd3 : 18'(i_radius_q8);
    assign qsq    = r_q * r_q;
    assign t_big  = div_ovf || (div_quot > gkb_pkg::T_LIMIT);
    assign uprod  = div_quot[21:0] * gkb_pkg::LOG2E_Q16;
    assign hprod  = r_p * r_f;
    assign hs     = hprod[46:16];
    assign coef   = gkb_pkg::exp2_coef(r_k);
    assign p_next = (hs > coef) ? 31'd0 : coef - hs;

    assign raw_zero = r_zero || (r_n > gkb_pkg::N_LIMIT);
    assign sh       = 5'd14 + r_n[4:0];
    assign rnd      = 32'd1 << (sh - 5'd1);
    assign s32      = {1'b0, r_p} + rnd;
    assign raw      = raw_zero ? 17'd0 : 17'(s32 >> sh);

    assign oprod = r_rd * r_inv;
    assign oadd  = oprod + gkb_pkg::OUT_ROUND;
    assign w18   = oadd[40:23];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_sum <= '0;
            r_inv <= '0;
        end else begin
            unique case (i_cmd.op)
                gkb_pkg::OP_LOAD: begin
                    r_radius <= i_radius_q8;
                    r_q      <= q_in;
                    r_r      <= RW'((17'(i_radius_q8) + 17'd255) >> 8);
                    r_idx    <= '0;
                    r_sum    <= '0;
                end
                gkb_pkg::OP_SETUP: begin
                    r_qsq <= qsq;
                end
                gkb_pkg::OP_EXPU: begin
                    r_zero <= t_big;
                    r_n    <= uprod[38:32];
                    r_f    <= uprod[31:16];
                    r_p    <= gkb_pkg::exp2_coef(3'd6);
                    r_k    <= 3'd5;
                end
                gkb_pkg::OP_HORNER: begin
                    r_p <= p_next;
                    r_k <= r_k - 3'd1;
                end
                gkb_pkg::OP_RAW: begin
                    r_sum <= r_sum + 23'(raw);
                    r_idx <= last_tap ? '0 : r_idx + 1'b1;
                end
                gkb_pkg::OP_INV: begin
                    r_inv <= div_quot;
                end
                gkb_pkg::OP_OUT: begin
                    r_o_weight <= (w18 > 18'd65535) ? 16'hFFFF : w18[15:0];
                    r_o_offset <= off7[5:0];
                    r_o_last   <= last_tap;
                    r_o_bad    <= 1'b0;
                end
                gkb_pkg::OP_NEXT: begin
                    r_idx <= r_idx + 1'b1;
                end
                gkb_pkg::OP_BAD: begin
                    r_o_weight <= '0;
                    r_o_offset <= '0;
                    r_o_last   <= 1'b1;
                    r_o_bad    <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // tap store
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == gkb_pkg::OP_RAW) begin
            r_mem[r_idx] <= raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == gkb_pkg::OP_RDMEM) begin
            r_rd <= r_mem[r_idx];
        end
    end

    assign o_stat.bad      = (r_radius == 16'd0) || ({1'b0, r_radius} > BAD_LIM);
    assign o_stat.div_done = div_done;
    assign o_stat.k_zero   = r_k == 3'd0;
    assign o_stat.last_tap = last_tap;
    assign o_stat.out_last = r_o_last;

    assign o_weight      = r_o_weight;
    assign o_tap_offset  = r_o_offset;
    assign o_last        = r_o_last;
    assign o_bad_request = r_o_bad;

endmodule

// File: rtl/core/gkb_ctrl.sv
// Sequencer of the gaussian kernel builder; drives datapath commands and handshakes.
// Uses gkb_pkg for command and status types.
`timescale 1ns / 1ps

module gkb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    input  gkb_pkg::t_stat  i_stat,
    output gkb_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_TAP,
        S_DIV,
        S_HORNER,
        S_RAW,
        S_RECIP,
        S_RDIV,
        S_RD,
        S_OUT,
        S_WAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;
    logic   r_out_valid;
    logic   n_out_valid;
    gkb_pkg::t_op op;

    always_comb begin
        n_state     = r_state;
        n_in_ready  = r_in_ready;
        n_out_valid = r_out_valid;
        op          = gkb_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && r_in_ready) begin
                    op         = gkb_pkg::OP_LOAD;
                    n_in_ready = 1'b0;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.bad) begin
                    op          = gkb_pkg::OP_BAD;
                    n_out_valid = 1'b1;
                    n_state     = S_WAIT;
                end else begin
                    op      = gkb_pkg::OP_SETUP;
                    n_state = S_TAP;
                end
            end
            S_TAP: begin
                op      = gkb_pkg::OP_TAP;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    op      = gkb_pkg::OP_EXPU;
                    n_state = S_HORNER;
                end
            end
            S_HORNER: begin
                op = gkb_pkg::OP_HORNER;
                if (i_stat.k_zero) begin
                    n_state = S_RAW;
                end
            end
            S_RAW: begin
                op      = gkb_pkg::OP_RAW;
                n_state = i_stat.last_tap ? S_RECIP : S_TAP;
            end
            S_RECIP: begin
                op      = gkb_pkg::OP_RECIP;
                n_state = S_RDIV;
            end
            S_RDIV: begin
                if (i_stat.div_done) begin
                    op      = gkb_pkg::OP_INV;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                op      = gkb_pkg::OP_RDMEM;
                n_state = S_OUT;
            end
            S_OUT: begin
                op          = gkb_pkg::OP_OUT;
                n_out_valid = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (i_res_ready) begin
                    n_out_valid = 1'b0;
                    if (i_stat.out_last) begin
                        n_in_ready = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        op      = gkb_pkg::OP_NEXT;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.op    = op;
    assign o_req_ready = r_in_ready;
    assign o_res_valid = r_out_valid;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_valid && r_in_ready))
        else $error("request and result sides open together");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_DIV || r_state == S_RDIV))
        else $error("divider finished outside a wait state");

    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_res_ready && i_stat.out_last) |=> r_in_ready)
        else $error("request side not reopened after final result");

    a_valid_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == S_WAIT)
        else $error("result shown outside the wait state");

endmodule

// File: rtl/core/gaussian_kernel_builder.sv
// Top level of the gaussian kernel builder: sequencer plus datapath.
// Uses gkb_pkg, gkb_req_if, gkb_res_if, gkb_ctrl and gkb_datapath.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake     | Payload
// i_req    | in  | valid / ready | radius_q8, sigma_q8 (unsigned 8.8)
// o_res    | out | valid / ready | weight Q0.16, tap_offset, last, bad_request
//
// One request at a time. A rejected request answers with a single result. A
// valid request computes each tap's exp weight with the shared bit-serial
// divider and six polynomial steps, then the reciprocal of the sum with the
// same divider, then for each result reads the tap store and scales it.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled result holds the sequencer in its wait state; requests are taken
// again once the last result of the request is accepted.

module gaussian_kernel_builder #(
    parameter int MAX_RADIUS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gkb_req_if.sink       i_req,
    gkb_res_if.source     o_res
);

    gkb_pkg::t_cmd  cmd;
    gkb_pkg::t_stat stat;

    // sequencer: owns the handshakes and steps the datapath
    gkb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: tap weights, sum, reciprocal and scaled result register
    gkb_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_radius_q8   (i_req.radius_q8),
        .i_sigma_q8    (i_req.sigma_q8),
        .o_weight      (o_res.weight),
        .o_tap_offset  (o_res.tap_offset),
        .o_last        (o_res.last),
        .o_bad_request (o_res.bad_request)
    );

endmodule

// File: verif/tb.sv
// Testbench of gaussian_kernel_builder: directed and random kernel requests,
// each result checked against a bit-accurate predictor. Uses gkb_if.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_R = 16;
    localparam int WATCHDOG_CYCLES = 20000;

    typedef struct packed {
        logic [15:0]       weight;
        logic signed [5:0] tap_offset;
        logic              last;
        logic              bad_request;
    } t_tap;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gkb_req_if req_ch();
    gkb_res_if res_ch();

    gaussian_kernel_builder #(.MAX_RADIUS(MAX_R)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_tap expected_taps[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   hold_off = 1'b0;
    int   sender_gap_max = 3;

    // Q30 coefficients of 2^-f, ln2^k / k!
    function automatic longint unsigned coef(input int k);
        case (k)
            0: return 64'd1073741824;
            1: return 64'd744261118;
            2: return 64'd257941248;
            3: return 64'd59597084;
            4: return 64'd10327388;
            5: return 64'd1431680;
            default: return 64'd165394;
        endcase
    endfunction

    // exp(-x2 / (2 sigma^2)) in Q16, sigma = q / 768
    function automatic longint unsigned gauss_q16(input longint unsigned x2,
                                                  input longint unsigned q);
        longint unsigned t, u, n, f, p, prod;
        t = (x2 * 64'd294912 * 64'd65536) / (q * q);
        if (t > (64'd32 << 16)) return 0;
        u = (t * 64'd94548) >> 16;
        n = u >> 16;
        f = u & 64'hFFFF;
        if (n > 16) return 0;
        p = coef(6);
        for (int k = 5; k >= 0; k--) begin
            prod = (p * f) >> 16;
            p = (prod > coef(k)) ? 64'd0 : coef(k) - prod;
        end
        return (p + (64'd1 << (13 + n))) >> (14 + n);
    endfunction

    // Queue the whole kernel this request should produce
    task automatic predict_kernel(input logic [15:0] radius, input logic [15:0] sigma);
        longint unsigned raw[33];
        longint unsigned sum, inv, w, q;
        int r, cnt;
        t_tap tap;
        if (radius == 0 || radius > MAX_R * 256) begin
            tap = '{weight: 16'd0, tap_offset: 6'sd0, last: 1'b1, bad_request: 1'b1};
            expected_taps.push_back(tap);
            return;
        end
        r = (radius + 255) >> 8;
        cnt = 2 * r + 1;
        q = (sigma != 0) ? longint'(sigma) * 3 : longint'(radius);
        sum = 0;
        for (int i = 0; i < cnt; i++) begin
            raw[i] = gauss_q16((i - r) * (i - r), q) & 64'h1FFFF;
            sum = (sum + raw[i]) & 64'h7FFFFF;
        end
        inv = (((64'd1 << 39) + sum / 2) / sum) & 64'hFFFFFF;
        for (int i = 0; i < cnt; i++) begin
            w = (raw[i] * inv + (64'd1 << 22)) >> 23;
            if (w > 65535) w = 65535;
            tap.weight = w[15:0];
            tap.tap_offset = 6'(i - r);
            tap.last = (i == cnt - 1);
            tap.bad_request = 1'b0;
            expected_taps.push_back(tap);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Bursty sender: offers one request, waits for acceptance; valid stays
    // high into the next request unless a gap is taken
    task automatic send_request(input logic [15:0] radius, input logic [15:0] sigma);
        if ($urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            req_ch.radius_q8 <= 16'($urandom);
            req_ch.sigma_q8 <= 16'($urandom);
            repeat ($urandom_range(1, sender_gap_max)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.radius_q8 <= radius;
        req_ch.sigma_q8 <= sigma;
        predict_kernel(radius, sigma);
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Receiver stall pattern, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 7) != 0);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_taps.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                t_tap e;
                e = expected_taps.pop_front();
                if (res_ch.weight !== e.weight)
                    report_mismatch($sformatf("weight %0d, want %0d (offset %0d)",
                                              res_ch.weight, e.weight, e.tap_offset));
                if (res_ch.tap_offset !== e.tap_offset)
                    report_mismatch($sformatf("tap_offset %0d, want %0d",
                                              res_ch.tap_offset, e.tap_offset));
                if (res_ch.last !== e.last)
                    report_mismatch($sformatf("last %0b, want %0b", res_ch.last, e.last));
                if (res_ch.bad_request !== e.bad_request)
                    report_mismatch($sformatf("bad_request %0b, want %0b",
                                              res_ch.bad_request, e.bad_request));
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic test_bad_radius();
        send_request(16'd0, 16'd256);
        send_request(16'(MAX_R * 256 + 1), 16'd0);
        send_request(16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_edges();
        send_request(16'd1, 16'd0);              // smallest radius, derived sigma
        send_request(16'(MAX_R * 256), 16'd0);   // largest radius
        send_request(16'(MAX_R * 256), 16'hFFFF);
        send_request(16'd256, 16'd1);            // tiny sigma: center saturates
        send_request(16'd768, 16'd0);
        send_request(16'd300, 16'd512);
        send_request(16'h0AAA, 16'h5555);
        send_request(16'h0555, 16'hAAAA);
    endtask

    // Long receiver hold-off while the sender keeps offering; long enough
    // for the first kernel to finish and sit on a stalled result
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (1500) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_request(16'd1024, 16'd300);
                send_request(16'd512, 16'd0);
                send_request(16'd0, 16'd0);
            end
        join
    endtask

    task automatic test_random(input int n);
        logic [15:0] rad, sig;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       rad = 16'($urandom);                       // mostly rejected
                1:       rad = 16'($urandom_range(2048, MAX_R * 256));
                default: rad = 16'($urandom_range(1, 1024));        // short kernels
            endcase
            case ($urandom_range(0, 5))
                0:       sig = 16'd0;
                1:       sig = 16'($urandom);
                default: sig = 16'($urandom_range(1, 2048));
            endcase
            sender_gap_max = (i % 40 < 20) ? 1 : 12;
            send_request(rad, sig);
        end
    endtask

    initial begin
        int settle;
        req_ch.valid = 1'b0;
        req_ch.radius_q8 = 16'd0;
        req_ch.sigma_q8 = 16'd0;
        res_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bad_radius();
        test_edges();
        test_backpressure();
        test_random(150);
        req_ch.valid <= 1'b0;
        settle = 0;
        while (expected_taps.size() != 0 && settle < 500000) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_taps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// File: gaussian_kernel_builder.f
rtl/core/gkb_pkg.sv
rtl/core/gkb_if.sv
rtl/core/gkb_div.sv
rtl/core/gkb_datapath.sv
rtl/core/gkb_ctrl.sv
rtl/core/gaussian_kernel_builder.sv
verif/tb.sv
